[rtl/llex_pkg.sv]
// ============================================================================
// llex_pkg: shared types and constants for the s-expression token lexer
// Result and queue-entry formats, token codes, character codes, keyword table.
// ============================================================================
package llex_pkg;

    localparam int unsigned CH_W        = 8;
    localparam int unsigned NUM_W       = 32;
    localparam int unsigned OUT_TDATA_W = 48;
    localparam int unsigned OUT_TUSER_W = 3;
    localparam int unsigned KW_COUNT    = 5;

    localparam logic [2:0] KIND_INT       = 3'd0;
    localparam logic [2:0] KIND_IDENT_CH  = 3'd1;
    localparam logic [2:0] KIND_IDENT_END = 3'd2;
    localparam logic [2:0] KIND_OP        = 3'd3;
    localparam logic [2:0] KIND_OPEN      = 3'd4;
    localparam logic [2:0] KIND_CLOSE     = 3'd5;
    localparam logic [2:0] KIND_END       = 3'd6;
    localparam logic [2:0] KIND_ERROR     = 3'd7;

    localparam logic [2:0] OP_PLUS  = 3'd0;
    localparam logic [2:0] OP_SUB   = 3'd1;
    localparam logic [2:0] OP_MUL   = 3'd2;
    localparam logic [2:0] OP_DIV   = 3'd3;
    localparam logic [2:0] OP_MOD   = 3'd4;

    localparam logic [2:0] KW_NAME  = 3'd0;

    localparam logic [4:0] KW_ALL   = 5'h1F;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_PLUS  = "+";
    localparam logic [7:0] CH_MINUS = "-";
    localparam logic [7:0] CH_STAR  = "*";
    localparam logic [7:0] CH_SLASH = "/";
    localparam logic [7:0] CH_PCT   = "%";
    localparam logic [7:0] CH_LPAR  = "(";
    localparam logic [7:0] CH_RPAR  = ")";

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [31:0] number;
        logic [7:0]         char_code;
        logic [2:0]         op_code;
        logic [2:0]         keyword;
        logic               last;
    } llex_result_t;

    typedef struct packed {
        logic         two;
        llex_result_t res_a;
        llex_result_t res_b;
    } llex_entry_t;

    function automatic llex_result_t make_result(
        input logic [2:0]  kind,
        input logic [31:0] number,
        input logic [7:0]  char_code,
        input logic [2:0]  op_code,
        input logic [2:0]  keyword
    );
        llex_result_t r;
        r.kind      = kind;
        r.number    = $signed(number);
        r.char_code = char_code;
        r.op_code   = op_code;
        r.keyword   = keyword;
        r.last      = 1'b0;
        return r;
    endfunction

    // keyword order: if, t, nil, setq, defun
    function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [2:0] pos);
        logic [7:0] c;
        c = 8'h00;
        case (k)
            3'd0:
            begin
                case (pos)
                    3'd0:    c = "i";
                    3'd1:    c = "f";
                    default: c = 8'h00;
                endcase
            end
            3'd1:
            begin
                case (pos)
                    3'd0:    c = "t";
                    default: c = 8'h00;
                endcase
            end
            3'd2:
            begin
                case (pos)
                    3'd0:    c = "n";
                    3'd1:    c = "i";
                    3'd2:    c = "l";
                    default: c = 8'h00;
                endcase
            end
            3'd3:
            begin
                case (pos)
                    3'd0:    c = "s";
                    3'd1:    c = "e";
                    3'd2:    c = "t";
                    3'd3:    c = "q";
                    default: c = 8'h00;
                endcase
            end
            3'd4:
            begin
                case (pos)
                    3'd0:    c = "d";
                    3'd1:    c = "e";
                    3'd2:    c = "f";
                    3'd3:    c = "u";
                    3'd4:    c = "n";
                    default: c = 8'h00;
                endcase
            end
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [2:0] kw_len(input logic [2:0] k);
        logic [2:0] n;
        case (k)
            3'd0:    n = 3'd2;
            3'd1:    n = 3'd1;
            3'd2:    n = 3'd3;
            3'd3:    n = 3'd4;
            3'd4:    n = 3'd5;
            default: n = 3'd0;
        endcase
        return n;
    endfunction

endpackage

[rtl/llex_front.sv]
// ============================================================================
// llex_front: character classifier and token state machine
// Accepts one character per cycle while in_ready is high and builds the results that it causes.
// ============================================================================
module llex_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic [7:0]           ch,
    output logic                 push,
    output llex_pkg::llex_entry_t push_entry
);
    import llex_pkg::*;

    localparam logic [2:0] M_IDLE  = 3'd0;
    localparam logic [2:0] M_MINUS = 3'd1;
    localparam logic [2:0] M_INT   = 3'd2;
    localparam logic [2:0] M_IDENT = 3'd3;
    localparam logic [2:0] M_ERR   = 3'd4;

    logic [2:0]   mode_reg, mode_next;
    logic [31:0]  accum_reg, accum_next;
    logic         neg_reg, neg_next;
    logic [4:0]   kwc_reg, kwc_next;
    logic [2:0]   pos_reg, pos_next;

    logic         accept;
    logic         is_digit, is_alpha, is_space;
    logic [7:0]   lc;
    logic [31:0]  digit_val;
    logic [31:0]  accum_x10;
    logic         run_idle;
    logic         flush_v, idle_v;
    llex_result_t flush_res, idle_res;

    function automatic logic [4:0] kw_filter(
        input logic [4:0] kwc,
        input logic [2:0] pos,
        input logic [7:0] c
    );
        logic [4:0] m;
        m = kwc;
        for (int k = 0; k < KW_COUNT; k++)
        begin
            if (pos >= kw_len(3'(k)) || kw_char(3'(k), pos) != c)
            begin
                m[k] = 1'b0;
            end
        end
        return m;
    endfunction

    function automatic logic [2:0] kw_end(input logic [4:0] kwc, input logic [2:0] pos);
        logic [2:0] kw;
        kw = KW_NAME;
        for (int k = 0; k < KW_COUNT; k++)
        begin
            if (kwc[k] && kw_len(3'(k)) == pos)
            begin
                kw = 3'(k + 1);
            end
        end
        return kw;
    endfunction

    assign accept    = in_valid && in_ready;
    assign is_digit  = (ch >= "0") && (ch <= "9");
    assign is_alpha  = ((ch >= "a") && (ch <= "z")) || ((ch >= "A") && (ch <= "Z"));
    assign is_space  = (ch == " ") || ((ch >= 8'd9) && (ch <= 8'd13));
    assign lc        = ((ch >= "A") && (ch <= "Z")) ? (ch + 8'd32) : ch;
    assign digit_val = {28'd0, ch[3:0]};
    assign accum_x10 = (accum_reg << 3) + (accum_reg << 1);

    always_comb
    begin
        mode_next  = mode_reg;
        accum_next = accum_reg;
        neg_next   = neg_reg;
        kwc_next   = kwc_reg;
        pos_next   = pos_reg;
        run_idle   = 1'b0;
        flush_v    = 1'b0;
        idle_v     = 1'b0;
        flush_res  = '0;
        idle_res   = '0;

        case (mode_reg)
            M_MINUS:
            begin
                if (is_digit)
                begin
                    mode_next  = M_INT;
                    accum_next = digit_val;
                    neg_next   = 1'b1;
                end
                else
                begin
                    flush_v   = 1'b1;
                    flush_res = make_result(KIND_OP, 32'd0, 8'd0, OP_SUB, KW_NAME);
                    run_idle  = 1'b1;
                end
            end
            M_INT:
            begin
                if (is_digit)
                begin
                    accum_next = accum_x10 + digit_val;
                end
                else
                begin
                    flush_v    = 1'b1;
                    flush_res  = make_result(KIND_INT,
                                             neg_reg ? (32'd0 - accum_reg) : accum_reg,
                                             8'd0, OP_PLUS, KW_NAME);
                    accum_next = 32'd0;
                    neg_next   = 1'b0;
                    run_idle   = 1'b1;
                end
            end
            M_IDENT:
            begin
                if (is_alpha || is_digit)
                begin
                    kwc_next = kw_filter(kwc_reg, pos_reg, lc);
                    pos_next = (pos_reg != 3'd7) ? (pos_reg + 3'd1) : pos_reg;
                    idle_v   = 1'b1;
                    idle_res = make_result(KIND_IDENT_CH, 32'd0, lc, OP_PLUS, KW_NAME);
                end
                else
                begin
                    flush_v   = 1'b1;
                    flush_res = make_result(KIND_IDENT_END, 32'd0, 8'd0, OP_PLUS,
                                            kw_end(kwc_reg, pos_reg));
                    kwc_next  = KW_ALL;
                    pos_next  = 3'd0;
                    run_idle  = 1'b1;
                end
            end
            M_ERR:
            begin
                run_idle = (ch == CH_NUL);
            end
            default:
            begin
                run_idle = 1'b1;
            end
        endcase

        if (run_idle)
        begin
            mode_next = M_IDLE;
            if (ch == CH_NUL)
            begin
                idle_v     = 1'b1;
                idle_res   = make_result(KIND_END, 32'd0, 8'd0, OP_PLUS, KW_NAME);
                accum_next = 32'd0;
                neg_next   = 1'b0;
                kwc_next   = KW_ALL;
                pos_next   = 3'd0;
            end
            else if (is_space)
            begin
                mode_next = M_IDLE;
            end
            else if (is_digit)
            begin
                mode_next  = M_INT;
                accum_next = digit_val;
                neg_next   = 1'b0;
            end
            else if (ch == CH_MINUS)
            begin
                mode_next = M_MINUS;
            end
            else if (is_alpha)
            begin
                mode_next = M_IDENT;
                kwc_next  = kw_filter(KW_ALL, 3'd0, lc);
                pos_next  = 3'd1;
                idle_v    = 1'b1;
                idle_res  = make_result(KIND_IDENT_CH, 32'd0, lc, OP_PLUS, KW_NAME);
            end
            else if (ch == CH_PLUS)
            begin
                idle_v   = 1'b1;
                idle_res = make_result(KIND_OP, 32'd0, 8'd0, OP_PLUS, KW_NAME);
            end
            else if (ch == CH_STAR)
            begin
                idle_v   = 1'b1;
                idle_res = make_result(KIND_OP, 32'd0, 8'd0, OP_MUL, KW_NAME);
            end
            else if (ch == CH_SLASH)
            begin
                idle_v   = 1'b1;
                idle_res = make_result(KIND_OP, 32'd0, 8'd0, OP_DIV, KW_NAME);
            end
            else if (ch == CH_PCT)
            begin
                idle_v   = 1'b1;
                idle_res = make_result(KIND_OP, 32'd0, 8'd0, OP_MOD, KW_NAME);
            end
            else if (ch == CH_LPAR)
            begin
                idle_v   = 1'b1;
                idle_res = make_result(KIND_OPEN, 32'd0, 8'd0, OP_PLUS, KW_NAME);
            end
            else if (ch == CH_RPAR)
            begin
                idle_v   = 1'b1;
                idle_res = make_result(KIND_CLOSE, 32'd0, 8'd0, OP_PLUS, KW_NAME);
            end
            else
            begin
                mode_next = M_ERR;
                idle_v    = 1'b1;
                idle_res  = make_result(KIND_ERROR, 32'd0, ch, OP_PLUS, KW_NAME);
            end
        end
    end

    always_comb
    begin
        push_entry.two   = flush_v && idle_v;
        push_entry.res_a = flush_v ? flush_res : idle_res;
        push_entry.res_b = idle_res;
        if (flush_v && idle_v)
        begin
            push_entry.res_b.last = 1'b1;
        end
        else
        begin
            push_entry.res_a.last = 1'b1;
        end
    end

    assign push = accept && (flush_v || idle_v);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= M_IDLE;
            accum_reg <= 32'd0;
            neg_reg   <= 1'b0;
            kwc_reg   <= KW_ALL;
            pos_reg   <= 3'd0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            accum_reg <= accum_next;
            neg_reg   <= neg_next;
            kwc_reg   <= kwc_next;
            pos_reg   <= pos_next;
        end
    end

endmodule

[rtl/llex_queue.sv]
// ============================================================================
// llex_queue: short result queue between front and back
// Holds one entry per character that caused results.
// ============================================================================
module llex_queue
#(
    parameter int unsigned DEPTH = 4
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  llex_pkg::llex_entry_t push_entry,
    output logic                  full,
    input  logic                  pop,
    output logic                  empty,
    output llex_pkg::llex_entry_t head
);
    import llex_pkg::*;

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    llex_entry_t      mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign head    = mem[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : (wr_ptr_reg + 1'b1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : (rd_ptr_reg + 1'b1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
        else $error("queue pop while empty");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not advance on push");

endmodule

[rtl/llex_back.sv]
// ============================================================================
// llex_back: result sequencer
// Drains queue entries onto the output stream, one or two results each.
// ============================================================================
module llex_back
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 empty,
    input  llex_pkg::llex_entry_t                head,
    output logic                                 pop,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // number, char_code, op_code, keyword, zero pad
    output logic [llex_pkg::OUT_TDATA_W-1:0]     m_tdata,
    // kind
    output logic [llex_pkg::OUT_TUSER_W-1:0]     m_tuser,
    output logic                                 m_tlast
);
    import llex_pkg::*;

    logic         sel_reg, sel_next;
    llex_result_t cur;
    logic         take;

    assign cur      = sel_reg ? head.res_b : head.res_a;
    assign m_tvalid = !empty;
    assign take     = m_tvalid && m_tready;
    assign pop      = take && (sel_reg || !head.two);
    assign sel_next = take ? (!sel_reg && head.two) : sel_reg;

    assign m_tdata = {2'b00, cur.keyword, cur.op_code, cur.char_code, cur.number};
    assign m_tuser = cur.kind;
    assign m_tlast = cur.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg <= 1'b0;
        end
        else
        begin
            sel_reg <= sel_next;
        end
    end

    a_sel_second: assert property (@(posedge clk) disable iff (!rst_n)
        sel_reg |-> (!empty && head.two))
        else $error("second result selected without a two-result entry");

endmodule

[rtl/lisp_token_lexer_core.sv]
// ============================================================================
// lisp_token_lexer_core: streaming s-expression tokenizer
// Each result is queued as its character is accepted and leaves from the
// queue head. Throughput: one character per cycle unless the queue is full;
// a character that flushes a token and starts another gives two results.
// The front stalls only when the QUEUE_DEPTH-entry result queue is full.
// Reset: rst_n clears the lexer state, the queue and the output sequencer.
// ============================================================================
module lisp_token_lexer_core
#(
    parameter int unsigned QUEUE_DEPTH = 4
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // ch
    input  logic [llex_pkg::CH_W-1:0]        s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // number, char_code, op_code, keyword, zero pad
    output logic [llex_pkg::OUT_TDATA_W-1:0] m_tdata,
    // kind
    output logic [llex_pkg::OUT_TUSER_W-1:0] m_tuser,
    output logic                             m_tlast
);
    import llex_pkg::*;

    logic        q_push, q_full, q_pop, q_empty;
    llex_entry_t q_push_entry, q_head;

    assign s_tready = !q_full;

    llex_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .ch         (s_tdata),
        .push       (q_push),
        .push_entry (q_push_entry)
    );

    llex_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .empty      (q_empty),
        .head       (q_head)
    );

    llex_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .empty    (q_empty),
        .head     (q_head),
        .pop      (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
